// ----- sv/sorted_breakpoint_bin_finder_core_assert.svh -----
// Assertion macros for the checker file of the breakpoint bin finder.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_BREAKPOINT_BIN_FINDER_CORE_ASSERT_SVH
`define SORTED_BREAKPOINT_BIN_FINDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sbbf_pkg.sv -----
package sbbf_pkg;

	// Request codes carried in the req_type field.
	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_LOCK   = 3'd1,
		REQ_FIND   = 3'd2,
		REQ_READ   = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_e;

	// Status codes returned with every result.
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_WRONG     = 3'd1,
		STAT_NOT_INC   = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_TOO_FEW   = 3'd4,
		STAT_UNDERFLOW = 3'd5,
		STAT_OVERFLOW  = 3'd6
	} status_e;

	// Controller states.
	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_e;

	// One request transaction.
	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] sample_value;
		logic [5:0]         entry_index;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         bin_index;
		logic signed [31:0] entry_value;
		logic [6:0]         entry_count;
	} rsp_t;

	// Control bits of a query travelling along the cell chain.
	typedef struct packed {
		logic vld;
		logic find;
	} qry_ctl_t;

endpackage

// ----- sv/sorted_breakpoint_bin_finder_core.sv -----
// Channel   Handshake                  Payload  Direction
// request   start high, busy low       cmd      in
// result    done high for one cycle    rsp      out
//
// Append, lock, clear, unknown requests and any rejected find or read give
// their result in the cycle after acceptance, with busy staying low.
// An accepted find or read runs a query through the chain of DEPTH cells,
// one cell per cycle; the result is registered once the query leaves the
// last cell, and busy is high while the query travels the chain.
// Reset clears the fill count, the lock and the chain control; the stored
// breakpoints are undefined until written. The receiver cannot stall results.
module sorted_breakpoint_bin_finder_core import sbbf_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int MIN_COUNT = 2,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fsm_e                          state_q;
	fsm_e                          state_d;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	logic                          locked_q;
	logic                          locked_d;
	logic signed [VALUE_WIDTH-1:0] first_q;
	logic signed [VALUE_WIDTH-1:0] first_d;
	logic signed [VALUE_WIDTH-1:0] last_q;
	logic signed [VALUE_WIDTH-1:0] last_d;
	logic signed [VALUE_WIDTH-1:0] x_vw;
	logic                          accept;
	logic                          append_ok;
	logic                          scan_go;
	logic [2:0]                    imm_status;
	logic                          done_q;
	rsp_t                          rsp_q;

	qry_ctl_t                      chain_ctl [0:DEPTH];
	logic signed [VALUE_WIDTH-1:0] chain_x   [0:DEPTH];
	logic [5:0]                    chain_idx [0:DEPTH];
	logic [IW-1:0]                 chain_bin [0:DEPTH];
	logic signed [VALUE_WIDTH-1:0] chain_val [0:DEPTH];

	assign accept = start && (state_q == FSM_IDLE);
	assign busy   = (state_q != FSM_IDLE);
	assign x_vw   = VALUE_WIDTH'(cmd.sample_value);

	// Request decode: status of requests answered at once, table updates, and
	// whether a query has to go down the chain.
	always_comb begin
		imm_status = STAT_OK;
		append_ok  = 1'b0;
		scan_go    = 1'b0;
		count_d    = count_q;
		locked_d   = locked_q;
		first_d    = first_q;
		last_d     = last_q;
		case (cmd.req_type)
			REQ_APPEND: begin
				if (locked_q) begin
					imm_status = STAT_WRONG;
				end else if (count_q == CW'(DEPTH)) begin
					imm_status = STAT_FULL;
				end else if ((count_q != '0) && (x_vw <= last_q)) begin
					imm_status = STAT_NOT_INC;
				end else begin
					append_ok = 1'b1;
					count_d   = count_q + CW'(1);
					last_d    = x_vw;
					if (count_q == '0) begin
						first_d = x_vw;
					end
				end
			end
			REQ_LOCK: begin
				if (!locked_q) begin
					if (32'(count_q) < 32'(MIN_COUNT)) begin
						imm_status = STAT_TOO_FEW;
					end else begin
						locked_d = 1'b1;
					end
				end
			end
			REQ_FIND: begin
				if (!locked_q || (count_q == '0)) begin
					imm_status = STAT_WRONG;
				end else if (x_vw < first_q) begin
					imm_status = STAT_UNDERFLOW;
				end else if (x_vw > last_q) begin
					imm_status = STAT_OVERFLOW;
				end else begin
					scan_go = 1'b1;
				end
			end
			REQ_READ: begin
				if (!locked_q) begin
					imm_status = STAT_WRONG;
				end else if ({{CW{1'b0}}, cmd.entry_index} >= {6'b0, count_q}) begin
					imm_status = STAT_OVERFLOW;
				end else begin
					scan_go = 1'b1;
				end
			end
			REQ_CLEAR: begin
				count_d  = '0;
				locked_d = 1'b0;
			end
			default: begin
				imm_status = STAT_WRONG;
			end
		endcase
	end

	// Controller next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept && scan_go) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (chain_ctl[DEPTH].vld) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Controller state and table control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			count_q  <= '0;
			locked_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !scan_go) || chain_ctl[DEPTH].vld;
			if (accept) begin
				count_q  <= count_d;
				locked_q <= locked_d;
			end
		end
	end

	// Copies of the first and newest breakpoints for the range checks, and
	// the result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= first_d;
			last_q  <= last_d;
		end
		if (accept && !scan_go) begin
			rsp_q.status      <= imm_status;
			rsp_q.bin_index   <= '0;
			rsp_q.entry_value <= '0;
			rsp_q.entry_count <= 7'({7'b0, count_d});
		end else if (chain_ctl[DEPTH].vld) begin
			rsp_q.status      <= STAT_OK;
			rsp_q.bin_index   <= 6'({6'b0, chain_bin[DEPTH]});
			rsp_q.entry_value <= 32'(chain_val[DEPTH]);
			rsp_q.entry_count <= 7'({7'b0, count_q});
		end
	end

	// The query enters the first cell in the cycle it is accepted.
	assign chain_ctl[0].vld  = accept && scan_go;
	assign chain_ctl[0].find = (cmd.req_type == REQ_FIND);
	assign chain_x[0]        = x_vw;
	assign chain_idx[0]      = cmd.entry_index;
	assign chain_bin[0]      = '0;
	assign chain_val[0]      = '0;

	// Row of breakpoint cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sbbf_cell #(
			.DEPTH       (DEPTH),
			.VALUE_WIDTH (VALUE_WIDTH),
			.CELL_INDEX  (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (count_q),
			.wr_en   (accept && append_ok),
			.wr_data (x_vw),
			.ctl_in  (chain_ctl[i]),
			.x_in    (chain_x[i]),
			.idx_in  (chain_idx[i]),
			.bin_in  (chain_bin[i]),
			.val_in  (chain_val[i]),
			.ctl_out (chain_ctl[i+1]),
			.x_out   (chain_x[i+1]),
			.idx_out (chain_idx[i+1]),
			.bin_out (chain_bin[i+1]),
			.val_out (chain_val[i+1])
		);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- sv/sbbf_cell.sv -----
// One cell of the breakpoint chain. It holds a single breakpoint and passes
// the travelling query on to its neighbour in the next cycle, updating the
// bin index or the read value when its own breakpoint is relevant.
module sbbf_cell import sbbf_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int VALUE_WIDTH = 32,
	parameter int CELL_INDEX = 0,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [CW-1:0]                 count,
	input  logic                          wr_en,
	input  logic signed [VALUE_WIDTH-1:0] wr_data,
	input  qry_ctl_t                      ctl_in,
	input  logic signed [VALUE_WIDTH-1:0] x_in,
	input  logic [5:0]                    idx_in,
	input  logic [IW-1:0]                 bin_in,
	input  logic signed [VALUE_WIDTH-1:0] val_in,
	output qry_ctl_t                      ctl_out,
	output logic signed [VALUE_WIDTH-1:0] x_out,
	output logic [5:0]                    idx_out,
	output logic [IW-1:0]                 bin_out,
	output logic signed [VALUE_WIDTH-1:0] val_out
);

	logic signed [VALUE_WIDTH-1:0] brk_q;
	qry_ctl_t                      ctl_q;
	logic signed [VALUE_WIDTH-1:0] x_q;
	logic [5:0]                    idx_q;
	logic [IW-1:0]                 bin_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          active;
	logic                          idx_match;
	logic [IW-1:0]                 bin_d;
	logic signed [VALUE_WIDTH-1:0] val_d;

	// The breakpoint is written when the table grows into this position.
	always_ff @(posedge clk) begin
		if (wr_en && (count == CW'(CELL_INDEX))) begin
			brk_q <= wr_data;
		end
	end

	// Only positions below the fill level take part in a query.
	assign active    = ctl_in.vld && (CW'(CELL_INDEX) < count);
	assign idx_match = ({{IW{1'b0}}, idx_in} == (IW + 6)'(CELL_INDEX));

	// The breakpoints rise along the chain, so the last cell at or below the
	// sample names the bin.
	always_comb begin
		bin_d = bin_in;
		val_d = val_in;
		if (active && ctl_in.find && (brk_q <= x_in)) begin
			bin_d = IW'(CELL_INDEX);
		end
		if (active && !ctl_in.find && idx_match) begin
			val_d = brk_q;
		end
	end

	// Query control hand-over to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// Query payload hand-over to the next cell.
	always_ff @(posedge clk) begin
		x_q   <= x_in;
		idx_q <= idx_in;
		bin_q <= bin_d;
		val_q <= val_d;
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign idx_out = idx_q;
	assign bin_out = bin_q;
	assign val_out = val_q;

endmodule

// ----- sv/sbbf_checker.sv -----
`include "sorted_breakpoint_bin_finder_core_assert.svh"

// Port-level checks on the request and result transactions.
module sbbf_checker import sbbf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	logic quick_req;

	// Requests that never need the chain are answered in the next cycle.
	assign quick_req = start && !busy && (cmd.req_type != REQ_FIND)
		&& (cmd.req_type != REQ_READ);

	`SBBF_ASSERT_NEXT(a_quick_result, quick_req, done, "quick request gave no result")

	`SBBF_ASSERT_NEXT(a_clear_empties, start && !busy && (cmd.req_type == REQ_CLEAR),
		done && (rsp.status == STAT_OK) && (rsp.entry_count == 7'd0), "clear failed")

	`SBBF_ASSERT_SAME(a_fail_zero, done && (rsp.status != STAT_OK),
		(rsp.bin_index == 6'd0) && (rsp.entry_value == 32'sd0), "failed result not zeroed")

	`SBBF_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

endmodule

bind sorted_breakpoint_bin_finder_core sbbf_checker u_checker (.*);
